[sv/fpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, operation codes and the stage word of the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_W    = 32;
  localparam int OP_W      = 4;
  // quotient bits produced by the divider chain, one per cell
  localparam int QUO_W     = WORD_W + FRAC_BITS;
  localparam int PROD_W    = 2 * WORD_W;

  localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
  localparam logic [OP_W-1:0] OP_MIN      = 4'd4;
  localparam logic [OP_W-1:0] OP_MAX      = 4'd5;
  localparam logic [OP_W-1:0] OP_INC      = 4'd6;
  localparam logic [OP_W-1:0] OP_DEC      = 4'd7;
  localparam logic [OP_W-1:0] OP_TO_INT   = 4'd8;
  localparam logic [OP_W-1:0] OP_FROM_INT = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] res;      // result of the simple operations
    logic                     lt;
    logic                     eq;
    logic                     gt;
    logic                     dz;
    logic signed [PROD_W-1:0] prod;     // exact product
    logic                     quo_neg;  // sign of the quotient
    logic [WORD_W-1:0]        den;      // divisor magnitude
    logic [WORD_W-1:0]        rem;      // partial remainder
    logic [QUO_W-1:0]         num;      // numerator bits still to shift in
    logic [QUO_W-1:0]         quo;      // quotient bits so far
  } stage_t;

endpackage

[sv/fpa_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_prep
// Entry stage: simple operations, flags, product and divider setup.
// ----------------------------------------------------------------------------
module fpa_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [fpa_pkg::OP_W-1:0]         operation_i,
  input  logic signed [fpa_pkg::WORD_W-1:0] operand_a_i,
  input  logic signed [fpa_pkg::WORD_W-1:0] operand_b_i,
  output logic                             valid_o,
  output fpa_pkg::stage_t                  stage_o
);

  logic                             valid_q;
  fpa_pkg::stage_t                  stage_d, stage_q;
  logic [fpa_pkg::WORD_W-1:0]       mag_a, mag_b;

  always_comb begin
    mag_a = operand_a_i[fpa_pkg::WORD_W-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    mag_b = operand_b_i[fpa_pkg::WORD_W-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    stage_d         = '0;
    stage_d.op      = operation_i;
    stage_d.lt      = operand_a_i < operand_b_i;
    stage_d.eq      = operand_a_i == operand_b_i;
    stage_d.gt      = operand_a_i > operand_b_i;
    stage_d.dz      = (operation_i == fpa_pkg::OP_DIV) && (operand_b_i == '0);
    stage_d.prod    = operand_a_i * operand_b_i;
    stage_d.quo_neg = operand_a_i[fpa_pkg::WORD_W-1] ^ operand_b_i[fpa_pkg::WORD_W-1];
    stage_d.den     = mag_b;
    stage_d.rem     = '0;
    stage_d.num     = {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
    stage_d.quo     = '0;
    case (operation_i)
      fpa_pkg::OP_ADD:      stage_d.res = operand_a_i + operand_b_i;
      fpa_pkg::OP_SUB:      stage_d.res = operand_a_i - operand_b_i;
      fpa_pkg::OP_MIN:      stage_d.res = (operand_b_i < operand_a_i) ? operand_b_i
                                                                      : operand_a_i;
      fpa_pkg::OP_MAX:      stage_d.res = (operand_b_i > operand_a_i) ? operand_b_i
                                                                      : operand_a_i;
      fpa_pkg::OP_INC:      stage_d.res = operand_a_i + 32'sd1;
      fpa_pkg::OP_DEC:      stage_d.res = operand_a_i - 1;
      fpa_pkg::OP_TO_INT:   stage_d.res = operand_a_i >>> fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_FROM_INT: stage_d.res = operand_a_i <<< fpa_pkg::FRAC_BITS;
      default:              stage_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[sv/fpa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring-division step: shift in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpa_pkg::stage_t stage_i,
  output logic            valid_o,
  output fpa_pkg::stage_t stage_o
);

  logic                         valid_q;
  fpa_pkg::stage_t              stage_d, stage_q;
  logic [fpa_pkg::WORD_W:0]     shifted;
  logic [fpa_pkg::WORD_W:0]     diff;
  logic                         fits;

  always_comb begin
    shifted = {stage_i.rem, stage_i.num[fpa_pkg::QUO_W-1]};
    diff    = shifted - {1'b0, stage_i.den};
    fits    = shifted >= {1'b0, stage_i.den};
    stage_d      = stage_i;
    stage_d.num  = {stage_i.num[fpa_pkg::QUO_W-2:0], 1'b0};
    stage_d.quo  = {stage_i.quo[fpa_pkg::QUO_W-2:0], fits};
    stage_d.rem  = fits ? diff[fpa_pkg::WORD_W-1:0] : shifted[fpa_pkg::WORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[sv/fpa_fin.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_fin
// Output stage: round product and quotient, apply signs, select result.
// ----------------------------------------------------------------------------
module fpa_fin (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  fpa_pkg::stage_t                   stage_i,
  output logic                              valid_o,
  output logic signed [fpa_pkg::WORD_W-1:0] result_o,
  output logic                              less_than_o,
  output logic                              equal_o,
  output logic                              greater_than_o,
  output logic                              divide_by_zero_o
);

  logic                             valid_q;
  logic [fpa_pkg::WORD_W-1:0]       res_d, res_q;
  logic [3:0]                       flags_q;
  logic [fpa_pkg::PROD_W-1:0]       pmag, pround;
  logic [fpa_pkg::WORD_W-1:0]       pres, qres;
  logic [fpa_pkg::QUO_W-1:0]        qround;

  always_comb begin
    pmag   = stage_i.prod[fpa_pkg::PROD_W-1] ? (~stage_i.prod + 1'b1) : stage_i.prod;
    pround = (pmag + (fpa_pkg::PROD_W'(1) << (fpa_pkg::FRAC_BITS - 1)))
             >> fpa_pkg::FRAC_BITS;
    pres   = stage_i.prod[fpa_pkg::PROD_W-1] ? (~pround[fpa_pkg::WORD_W-1:0] + 1'b1)
                                             : pround[fpa_pkg::WORD_W-1:0];
    // round up when twice the remainder reaches the divisor
    qround = stage_i.quo + fpa_pkg::QUO_W'({stage_i.rem, 1'b0} >= {1'b0, stage_i.den});
    qres   = stage_i.quo_neg ? (~qround[fpa_pkg::WORD_W-1:0] + 1'b1)
                             : qround[fpa_pkg::WORD_W-1:0];
    case (stage_i.op)
      fpa_pkg::OP_MUL: res_d = pres;
      fpa_pkg::OP_DIV: res_d = stage_i.dz ? '0 : qres;
      default:         res_d = stage_i.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_d;
      flags_q <= {stage_i.lt, stage_i.eq, stage_i.gt, stage_i.dz};
    end
  end

  assign valid_o          = valid_q;
  assign result_o         = res_q;
  assign less_than_o      = flags_q[3];
  assign equal_o          = flags_q[2];
  assign greater_than_o   = flags_q[1];
  assign divide_by_zero_o = flags_q[0];

endmodule

[sv/fixed_point_q24_8_alu_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Signed Q24.8 ALU with a pipelined restoring divider chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i, in_stall_o, operation_i, operand_a_i and
//   operand_b_i. A word is taken at a clock edge with valid high and stall
//   low. Output channel: out_valid_o, out_stall_i and the result fields.
//   Every input word yields exactly one output word, in order.
//   The pipeline has one entry stage (decode, flags, 32x32 multiply),
//   one cell per quotient bit (40 cells, each a 33-bit trial subtract),
//   and one output register that rounds and signs product and quotient.
//   Throughput is one word per cycle while no output stall holds the chain; all stages advance together.
//   When the receiver stalls a valid output word, the whole chain holds and
//   in_stall_o rises in the same cycle; the output word stays put.
//   Reset clears every valid bit; the block accepts words right after.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fpa_pkg::OP_W-1:0]          operation_i,
  input  logic signed [fpa_pkg::WORD_W-1:0] operand_a_i,
  input  logic signed [fpa_pkg::WORD_W-1:0] operand_b_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fpa_pkg::WORD_W-1:0] result_o,
  output logic                              less_than_o,
  output logic                              equal_o,
  output logic                              greater_than_o,
  output logic                              divide_by_zero_o
);

  logic            en;
  logic            valid_c [fpa_pkg::QUO_W+1];
  fpa_pkg::stage_t stage_c [fpa_pkg::QUO_W+1];

  // advance unless the output word is waiting on the receiver
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  fpa_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (valid_c[0]),
    .stage_o     (stage_c[0])
  );

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < fpa_pkg::QUO_W; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .stage_i (stage_c[i]),
      .valid_o (valid_c[i+1]),
      .stage_o (stage_c[i+1])
    );
  end

  fpa_fin u_fin (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (valid_c[fpa_pkg::QUO_W]),
    .stage_i          (stage_c[fpa_pkg::QUO_W]),
    .valid_o          (out_valid_o),
    .result_o         (result_o),
    .less_than_o      (less_than_o),
    .equal_o          (equal_o),
    .greater_than_o   (greater_than_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

[bench/fixed_point_q24_8_alu_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top_tb
// Self-checking bench for the Q24.8 ALU: directed corner words, then random
// words with random gaps and stalls on both channels; every output word is
// compared field by field with an in-order prediction.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top_tb;

  typedef struct {
    logic signed [31:0] res;
    logic lt, eq, gt, dz;
  } alu_word_t;

  // Scoreboard: predicts each accepted word and checks outputs in order.
  class alu_scoreboard;
    alu_word_t pending[$];
    int errors;
    int checked;

    function automatic logic [31:0] round_mul(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] prod;
      logic [63:0] mag;
      prod = 64'(a) * 64'(b);
      mag = prod[63] ? -prod : prod;
      mag = (mag + 64'd128) >> fpa_pkg::FRAC_BITS;
      return prod[63] ? 32'(-mag) : 32'(mag);
    endfunction

    function automatic logic [31:0] round_div(logic signed [31:0] a, logic signed [31:0] b);
      logic [63:0] num, den, q, r;
      num = (a[31] ? -64'(a) : 64'(a)) << fpa_pkg::FRAC_BITS;
      den = b[31] ? -64'(b) : 64'(b);
      q = num / den;
      r = num % den;
      if (2 * r >= den) q++;
      return (a[31] != b[31]) ? 32'(-q) : 32'(q);
    endfunction

    function void note_input(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      alu_word_t w;
      w.res = '0;
      w.dz = 1'b0;
      case (op)
        fpa_pkg::OP_ADD:      w.res = a + b;
        fpa_pkg::OP_SUB:      w.res = a - b;
        fpa_pkg::OP_MUL:      w.res = round_mul(a, b);
        fpa_pkg::OP_DIV:      if (b == 0) w.dz = 1'b1; else w.res = round_div(a, b);
        fpa_pkg::OP_MIN:      w.res = (b < a) ? b : a;
        fpa_pkg::OP_MAX:      w.res = (b > a) ? b : a;
        fpa_pkg::OP_INC:      w.res = a + 1;
        fpa_pkg::OP_DEC:      w.res = a - 1;
        fpa_pkg::OP_TO_INT:   w.res = a >>> fpa_pkg::FRAC_BITS;
        fpa_pkg::OP_FROM_INT: w.res = a << fpa_pkg::FRAC_BITS;
        default:              w.res = '0;
      endcase
      w.lt = a < b;
      w.eq = a == b;
      w.gt = a > b;
      pending.push_back(w);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_output(alu_word_t got);
      alu_word_t e;
      if (pending.size() == 0) begin
        report("output word with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.res !== e.res)
        report($sformatf("result got %h want %h", got.res, e.res));
      if (got.lt !== e.lt) report("less_than");
      if (got.eq !== e.eq) report("equal");
      if (got.gt !== e.gt) report("greater_than");
      if (got.dz !== e.dz) report("divide_by_zero");
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [3:0] operation_i = '0;
  logic signed [31:0] operand_a_i = '0, operand_b_i = '0;
  logic in_stall_o, out_valid_o;
  logic signed [31:0] result_o;
  logic less_than_o, equal_o, greater_than_o, divide_by_zero_o;

  fixed_point_q24_8_alu_top dut (.*);

  alu_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  bit calm = 0;  // when set, neither side idles
  localparam int LIMIT = 400000;

  initial forever #5 clk_i = ~clk_i;

  // Count cycles and bail out on a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sample accepted words on both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_input(operation_i, operand_a_i, operand_b_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_output('{result_o, less_than_o, equal_o, greater_than_o, divide_by_zero_o});
  end

  // Stall the output at random; drive at the falling edge.
  always @(negedge clk_i)
    out_stall_i <= (!calm && $urandom_range(99) < 37);

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 2047)) - 32'sd1024);
      3: return $signed(32'($urandom) >>> $urandom_range(31));
      4: return 32'sd0;
      default: return $signed($urandom);
    endcase
  endfunction

  // Offer one word and hold it until the block takes it.
  task send_word(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    logic signed [31:0] corners[6];
    corners = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd256, -32'sd256, -32'sd1};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: every operation code on corner pairs, ties in rounding,
    // divide by zero, wrap of inc/dec, unused codes.
    for (int op = 0; op < 16; op++)
      send_word(4'(op), corners[op % 6], corners[(op + 2) % 6]);
    send_word(fpa_pkg::OP_DIV, 32'sd256, 32'sd0);
    send_word(fpa_pkg::OP_INC, 32'sh7fffffff, 32'sd0);
    send_word(fpa_pkg::OP_DEC, 32'sh80000000, 32'sd0);
    send_word(fpa_pkg::OP_MUL, 32'sd384, 32'sd1);       // tie, rounds away from zero
    send_word(fpa_pkg::OP_MUL, -32'sd384, 32'sd1);
    send_word(fpa_pkg::OP_MIN, 32'sd5, 32'sd5);
    send_word(fpa_pkg::OP_TO_INT, -32'sd1, 32'sd0);
    send_word(fpa_pkg::OP_DIV, 32'sh80000000, -32'sd1);

    // Random: mostly valid codes, a few unused ones, with a calm stretch.
    for (int i = 0; i < 1900; i++) begin
      calm = (i >= 800 && i < 1000);
      send_word($urandom_range(99) < 95 ? 4'($urandom_range(9)) : 4'($urandom_range(10, 15)),
                pick_operand(), pick_operand());
    end
    calm = 0;
    @(negedge clk_i) in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d words across all sixteen operation codes, %0d checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
